// ===== sv/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// jps_pkg
// Shared widths, register indexes and transaction types for the Jacobi
// 5-point stencil sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jps_pkg;

  localparam int DATA_W        = 32;
  localparam int GEOM_W        = 11;
  localparam int STEP_W        = 31;
  localparam int TOL_W         = 32;
  localparam int ESUM_W        = 64;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam int MAX_COLS_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_ROWS      = 1024;
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int MIN_DIM       = 3;

  localparam int ITEM_Q_DEPTH  = 4;
  localparam int RES_Q_DEPTH   = 2;
  localparam int QCNT_W        = $clog2(ITEM_Q_DEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SQUARED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_STEP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL_SQUARED  = 3'd4;

  localparam logic signed [2*DATA_W-1:0] NV_MAX = 64'sd2147483647;
  localparam logic signed [2*DATA_W-1:0] NV_MIN = -64'sd2147483648;

  // operands of one interior point
  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] right;
    logic signed [DATA_W-1:0] down;
    logic signed [DATA_W-1:0] fcg;
    logic signed [DATA_W-1:0] mid_old;
    logic                     last;
    logic                     clr;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic                     last;
    logic                     converged;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/jps_ram.sv =====
// ----------------------------------------------------------------------------
// jps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jps_queue.sv =====
// ----------------------------------------------------------------------------
// jps_queue
// Small register FIFO with occupancy count, used between front and back and
// as the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic                            full,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jps_front.sv =====
// ----------------------------------------------------------------------------
// jps_front
// Raster position tracking, line buffers and stencil window; classifies each
// grid point and hands interior points to the arithmetic queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jps_front #(
  parameter int MAX_COLS = jps_pkg::MAX_COLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire logic signed [jps_pkg::DATA_W-1:0]  value,
  input  wire logic signed [jps_pkg::DATA_W-1:0]  forcing,
  output logic                                    full,
  input  wire logic [jps_pkg::GEOM_W-1:0]         grid_cols,
  input  wire logic [jps_pkg::GEOM_W-1:0]         grid_rows,
  input  wire logic [jps_pkg::QCNT_W-1:0]         q_count,
  output logic                                    item_push,
  output jps_pkg::item_t                          item
);

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = AW + 1;
  localparam int GW  = jps_pkg::GEOM_W;
  localparam int KW  = (CW > GW) ? CW : GW;
  localparam int RW  = jps_pkg::ROW_W;
  localparam int DW  = jps_pkg::DATA_W;
  localparam int QW  = jps_pkg::QCNT_W;
  localparam int QW1 = QW + 1;

  logic [AW-1:0] col_count;
  logic [AW-1:0] col_count_next;
  logic [RW-1:0] row_count;
  logic [RW-1:0] row_count_next;
  logic [CW-1:0] cols;
  logic [GW-1:0] rows;
  logic [AW-1:0] c;
  logic [GW-1:0] r_pre;
  logic [RW-1:0] r;
  logic [CW-1:0] c_inc;
  logic [GW-1:0] r_inc;
  logic          interior;
  logic          is_last;
  logic          is_clr;
  logic          right_zero;
  logic          accept;
  logic [QW1-1:0] occ;

  logic          s1_valid;
  logic [AW-1:0] s1_c;
  logic [DW-1:0] s1_down;
  logic          s1_interior;
  logic          s1_last;
  logic          s1_clr;
  logic          s1_right_zero;
  logic [DW-1:0] left;
  logic          clr_pending;
  logic          clr_pending_next;

  logic [DW-1:0] mid_a_rdata;
  logic [DW-1:0] mid_b_rdata;
  logic [DW-1:0] above_rdata;
  logic [DW-1:0] forc_rdata;

  always_comb begin
    if (KW'(grid_cols) < KW'(jps_pkg::MIN_DIM)) begin
      cols = CW'(jps_pkg::MIN_DIM);
    end else if (KW'(grid_cols) > KW'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(grid_cols);
    end
    if (grid_rows < GW'(jps_pkg::MIN_DIM)) begin
      rows = GW'(jps_pkg::MIN_DIM);
    end else if (grid_rows > GW'(jps_pkg::MAX_ROWS)) begin
      rows = GW'(jps_pkg::MAX_ROWS);
    end else begin
      rows = grid_rows;
    end
  end

  // position of the arriving point and of the next one
  always_comb begin
    if (CW'(col_count) >= cols) begin
      c     = '0;
      r_pre = GW'(row_count) + GW'(1);
    end else begin
      c     = col_count;
      r_pre = GW'(row_count);
    end
    r     = (r_pre >= rows) ? '0 : RW'(r_pre);
    c_inc = CW'(c) + CW'(1);
    r_inc = GW'(r) + GW'(1);
    if (c_inc >= cols) begin
      col_count_next = '0;
      row_count_next = (r_inc >= rows) ? '0 : RW'(r_inc);
    end else begin
      col_count_next = AW'(c_inc);
      row_count_next = r;
    end
    interior   = (r >= RW'(2)) && (c != '0) && (CW'(c) <= cols - CW'(2));
    is_last    = (GW'(r) == rows - GW'(1)) && (CW'(c) == cols - CW'(2));
    is_clr     = (r == '0) && (c == '0);
    right_zero = (c_inc == CW'(MAX_COLS));
  end

  assign occ    = QW1'(q_count) + QW1'(s1_valid);
  assign full   = (occ >= QW1'(jps_pkg::ITEM_Q_DEPTH));
  assign accept = push && !full;

  // line buffers, row_middle kept twice for the centre and right taps
  jps_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_mid_a (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (value),
    .raddr (c),
    .rdata (mid_a_rdata)
  );

  jps_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_mid_b (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (value),
    .raddr (AW'(c_inc)),
    .rdata (mid_b_rdata)
  );

  jps_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_above (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata (mid_a_rdata),
    .raddr (c),
    .rdata (above_rdata)
  );

  jps_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_forc (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (forcing),
    .raddr (c),
    .rdata (forc_rdata)
  );

  always_comb begin
    clr_pending_next = clr_pending;
    if (s1_valid && s1_clr) begin
      clr_pending_next = 1'b1;
    end else if (s1_valid && s1_interior) begin
      clr_pending_next = 1'b0;
    end
  end

  always_comb begin
    item_push    = s1_valid && s1_interior;
    item.left    = left;
    item.up      = above_rdata;
    item.right   = s1_right_zero ? '0 : mid_b_rdata;
    item.down    = s1_down;
    item.fcg     = forc_rdata;
    item.mid_old = mid_a_rdata;
    item.last    = s1_last;
    item.clr     = clr_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      s1_valid    <= 1'b0;
      clr_pending <= 1'b0;
      left        <= '0;
    end else begin
      s1_valid    <= accept;
      clr_pending <= clr_pending_next;
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (s1_valid) begin
        left <= mid_a_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c          <= c;
      s1_down       <= value;
      s1_interior   <= interior;
      s1_last       <= is_last;
      s1_clr        <= is_clr;
      s1_right_zero <= right_zero;
    end
  end

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    item_push |-> (q_count < QW'(jps_pkg::ITEM_Q_DEPTH)))
    else $error("interior point pushed into a full queue");

endmodule

`default_nettype wire

// ===== sv/jps_back.sv =====
// ----------------------------------------------------------------------------
// jps_back
// Stencil arithmetic pipeline: new value, squared change, saturating error
// sum and convergence compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jps_back #(
  parameter int FRAC_BITS = jps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire jps_pkg::item_t              q_item,
  output logic                             q_pop,
  input  wire logic [jps_pkg::STEP_W-1:0]  step_squared,
  input  wire logic [jps_pkg::STEP_W-1:0]  grid_step,
  input  wire logic [jps_pkg::TOL_W-1:0]   tol_squared,
  input  wire logic                        out_full,
  output logic                             out_push,
  output jps_pkg::res_t                    out_res
);

  localparam int DW = jps_pkg::DATA_W;
  localparam int SW = DW + 2;
  localparam int PW = 2 * DW;
  localparam int EW = jps_pkg::ESUM_W;
  localparam int TW = EW - FRAC_BITS;
  localparam int HW = EW / 2;
  localparam int LW = jps_pkg::STEP_W + HW;
  localparam int XW = LW + HW;

  logic adv;

  logic signed [DW-1:0] ss;
  logic signed [SW-1:0] sum4_next;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] hf;
  logic signed [PW-1:0] tot;
  logic signed [PW-1:0] q4;
  logic signed [DW-1:0] nv_next;
  logic signed [DW:0]   diff;
  logic [DW-1:0]        d_next;
  logic [PW-1:0]        sq;
  logic [TW-1:0]        term_next;
  logic [EW-1:0]        base;
  logic [EW:0]          acc;
  logic [EW-1:0]        esum_next;
  logic [LW-1:0]        plo_next;
  logic [LW-1:0]        phi_next;
  logic [XW-1:0]        total;
  logic [XW-1:0]        thr;
  logic                 conv_next;

  logic                 s1_valid;
  logic signed [SW-1:0] s1_sum4;
  logic signed [PW-1:0] s1_prod;
  logic signed [DW-1:0] s1_mid;
  logic                 s1_last;
  logic                 s1_clr;

  logic                 s2_valid;
  logic signed [DW-1:0] s2_nv;
  logic signed [DW-1:0] s2_mid;
  logic                 s2_last;
  logic                 s2_clr;

  logic                 s3_valid;
  logic [DW-1:0]        s3_d;
  logic signed [DW-1:0] s3_nv;
  logic                 s3_last;
  logic                 s3_clr;

  logic                 s4_valid;
  logic [TW-1:0]        s4_term;
  logic signed [DW-1:0] s4_nv;
  logic                 s4_last;
  logic                 s4_clr;

  logic                 s5_valid;
  logic signed [DW-1:0] s5_nv;
  logic                 s5_last;
  logic [EW-1:0]        esum;

  logic                 s6_valid;
  logic [LW-1:0]        s6_plo;
  logic [HW-1:0]        s6_ehi;
  logic signed [DW-1:0] s6_nv;
  logic                 s6_last;

  logic                 s7_valid;
  logic [LW-1:0]        s7_phi;
  logic [LW-1:0]        s7_plo;
  logic signed [DW-1:0] s7_nv;
  logic                 s7_last;

  logic                 s8_valid;
  logic signed [DW-1:0] s8_nv;
  logic                 s8_last;
  logic                 s8_conv;

  assign adv      = !s8_valid || !out_full;
  assign q_pop    = adv && !q_empty;
  assign out_push = s8_valid && !out_full;

  always_comb begin
    out_res.new_value = s8_nv;
    out_res.last      = s8_last;
    out_res.converged = s8_conv;
  end

  // neighbour sum and h2*f product
  always_comb begin
    ss        = signed'({1'b0, step_squared});
    sum4_next = SW'(q_item.left) + SW'(q_item.up) + SW'(q_item.right) + SW'(q_item.down);
    prod_next = PW'(ss) * PW'(q_item.fcg);
  end

  // quarter and saturate
  always_comb begin
    hf  = s1_prod >>> FRAC_BITS;
    tot = PW'(s1_sum4) + hf;
    q4  = tot >>> 2;
    if (q4 > jps_pkg::NV_MAX) begin
      nv_next = DW'(jps_pkg::NV_MAX);
    end else if (q4 < jps_pkg::NV_MIN) begin
      nv_next = DW'(jps_pkg::NV_MIN);
    end else begin
      nv_next = DW'(q4);
    end
  end

  // absolute change, its scaled square, error accumulation
  always_comb begin
    diff      = (DW + 1)'(s2_nv) - (DW + 1)'(s2_mid);
    d_next    = diff[DW] ? DW'(-diff) : DW'(diff);
    sq        = PW'(s3_d) * PW'(s3_d);
    term_next = sq[PW-1:FRAC_BITS];
    base      = s4_clr ? '0 : esum;
    acc       = (EW + 1)'(base) + (EW + 1)'(s4_term);
    esum_next = acc[EW] ? '1 : acc[EW-1:0];
  end

  // grid_step * error_sum in two halves, then exact compare
  always_comb begin
    plo_next  = LW'(grid_step) * LW'(esum[HW-1:0]);
    phi_next  = LW'(grid_step) * LW'(s6_ehi);
    total     = {s7_phi, {HW{1'b0}}} + XW'(s7_plo);
    thr       = XW'(tol_squared) << FRAC_BITS;
    conv_next = s7_last && (total < thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      esum     <= '0;
    end else if (adv) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      if (s4_valid) begin
        esum <= esum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum4 <= sum4_next;
      s1_prod <= prod_next;
      s1_mid  <= q_item.mid_old;
      s1_last <= q_item.last;
      s1_clr  <= q_item.clr;

      s2_nv   <= nv_next;
      s2_mid  <= s1_mid;
      s2_last <= s1_last;
      s2_clr  <= s1_clr;

      s3_d    <= d_next;
      s3_nv   <= s2_nv;
      s3_last <= s2_last;
      s3_clr  <= s2_clr;

      s4_term <= term_next;
      s4_nv   <= s3_nv;
      s4_last <= s3_last;
      s4_clr  <= s3_clr;

      s5_nv   <= s4_nv;
      s5_last <= s4_last;

      s6_plo  <= plo_next;
      s6_ehi  <= esum[EW-1:HW];
      s6_nv   <= s5_nv;
      s6_last <= s5_last;

      s7_phi  <= phi_next;
      s7_plo  <= s6_plo;
      s7_nv   <= s6_nv;
      s7_last <= s6_last;

      s8_nv   <= s7_nv;
      s8_last <= s7_last;
      s8_conv <= conv_next;
    end
  end

  a_conv_on_last: assert property (@(posedge clk) disable iff (rst)
    (s8_valid && s8_conv) |-> s8_last)
    else $error("converged flag on a point that is not the last one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s8_valid && !adv) |=> (s8_valid && $stable(s8_nv)))
    else $error("result lost while the output buffer is full");

  a_esum_grows: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && adv && !s4_clr) |=> (esum >= $past(esum)))
    else $error("error sum decreased without a sweep start");

endmodule

`default_nettype wire

// ===== sv/jacobi_poisson_stencil_sweep.sv =====
// ----------------------------------------------------------------------------
// jacobi_poisson_stencil_sweep
// One Jacobi sweep of the 5-point Poisson stencil in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Grid points stream in raster order, boundaries included, one transaction
// per clock with its forcing value while full is low; one clock per point
// is sustained, set by the single read port of each line buffer (the middle
// row is stored twice so centre and right taps are read in the same cycle).
// A result is emitted for each interior point once the point below it
// arrives; the item is registered at the line buffer read, then passes
// the transfer queue and an eight stage arithmetic pipeline that ends
// in the result queue. The last interior point of a sweep carries last, and
// converged tells whether grid_step times the saturating sum of squared
// changes lies below tol_squared. The line buffers are not cleared at
// reset; only the first two rows of a sweep fill them before they are read.
// Write configuration only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_poisson_stencil_sweep #(
  parameter int MAX_COLS  = jps_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = jps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [jps_pkg::DATA_W-1:0]     value,
  input  wire logic signed [jps_pkg::DATA_W-1:0]     forcing,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed [jps_pkg::DATA_W-1:0]          new_value,
  output logic                                       last,
  output logic                                       converged,
  input  wire logic                                  cfg_write,
  input  wire logic [jps_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire logic [jps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int GW  = jps_pkg::GEOM_W;
  localparam int SW  = jps_pkg::STEP_W;
  localparam int TW  = jps_pkg::TOL_W;
  localparam int IW  = $bits(jps_pkg::item_t);
  localparam int OW  = $bits(jps_pkg::res_t);
  localparam int RCW = $clog2(jps_pkg::RES_Q_DEPTH + 1);

  logic [GW-1:0] grid_cols;
  logic [GW-1:0] grid_rows;
  logic [SW-1:0] step_squared;
  logic [SW-1:0] grid_step;
  logic [TW-1:0] tol_squared;

  logic                         item_push;
  jps_pkg::item_t               item;
  logic [jps_pkg::QCNT_W-1:0]   q_count;
  logic [IW-1:0]                q_rdata;
  jps_pkg::item_t               q_item;
  logic                         q_empty;
  logic                         q_full;
  logic                         q_pop;

  logic                         out_push;
  jps_pkg::res_t                out_res;
  logic                         out_full;
  logic [OW-1:0]                res_rdata;
  logic [RCW-1:0]               res_count;
  jps_pkg::res_t                res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= GW'(jps_pkg::MIN_DIM);
      grid_rows    <= GW'(jps_pkg::MIN_DIM);
      step_squared <= '0;
      grid_step    <= '0;
      tol_squared  <= '0;
    end else if (cfg_write) begin
      case (cfg_addr)
        jps_pkg::REG_GRID_COLS: begin
          grid_cols <= cfg_data[GW-1:0];
        end
        jps_pkg::REG_GRID_ROWS: begin
          grid_rows <= cfg_data[GW-1:0];
        end
        jps_pkg::REG_STEP_SQUARED: begin
          step_squared <= cfg_data[SW-1:0];
        end
        jps_pkg::REG_GRID_STEP: begin
          grid_step <= cfg_data[SW-1:0];
        end
        jps_pkg::REG_TOL_SQUARED: begin
          tol_squared <= cfg_data[TW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  jps_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .value     (value),
    .forcing   (forcing),
    .full      (full),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .q_count   (q_count),
    .item_push (item_push),
    .item      (item)
  );

  jps_queue #(.WIDTH(IW), .DEPTH(jps_pkg::ITEM_Q_DEPTH)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (item_push),
    .wdata (item),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  assign q_item = jps_pkg::item_t'(q_rdata);

  jps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .step_squared (step_squared),
    .grid_step    (grid_step),
    .tol_squared  (tol_squared),
    .out_full     (out_full),
    .out_push     (out_push),
    .out_res      (out_res)
  );

  jps_queue #(.WIDTH(OW), .DEPTH(jps_pkg::RES_Q_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .full  (out_full),
    .count (res_count)
  );

  assign res       = jps_pkg::res_t'(res_rdata);
  assign new_value = res.new_value;
  assign last      = res.last;
  assign converged = res.converged;

  a_item_q_safe: assert property (@(posedge clk) disable iff (rst)
    item_push |-> !q_full)
    else $error("transaction dropped at the item queue");

  a_res_q_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RCW'(jps_pkg::RES_Q_DEPTH))
    else $error("result queue holds more than its depth");

endmodule

`default_nettype wire
